// ===== rtl/core/rsp_pkg.sv =====
// Shared types and constants for the Roman surface point evaluator.
package rsp_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam int ANG_W = 16;
    localparam int TRIG_W = 22;   // Q20 signed, |value| <= 2^20
    localparam int OUT_W = 26;
    localparam int CX_W = 33;     // Q30 CORDIC datapath
    localparam int CZ_W = 26;

    typedef logic signed [TRIG_W-1:0] trig_t;

    // Front-end record queued to the back end: angles plus the radius in effect.
    typedef struct packed {
        logic [ANG_W-1:0] u_angle;
        logic [ANG_W-1:0] v_angle;
        logic [15:0]      radius;
    } rsp_job_t;

    // One pipeline stage of a CORDIC lane.
    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
        logic                   neg;
    } rsp_cordic_t;

    function automatic logic signed [CZ_W-1:0] atan_turn24(input int i);
        logic signed [CZ_W-1:0] r;
        begin
            case (i)
                0: r = 26'sd2097152;
                1: r = 26'sd1238021;
                2: r = 26'sd654136;
                3: r = 26'sd332050;
                4: r = 26'sd166669;
                5: r = 26'sd83416;
                6: r = 26'sd41718;
                7: r = 26'sd20860;
                8: r = 26'sd10430;
                9: r = 26'sd5215;
                10: r = 26'sd2608;
                11: r = 26'sd1304;
                12: r = 26'sd652;
                13: r = 26'sd326;
                14: r = 26'sd163;
                15: r = 26'sd81;
                16: r = 26'sd41;
                17: r = 26'sd20;
                18: r = 26'sd10;
                default: r = 26'sd5;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/rsp_front.sv =====
// Front end: accepts parameter pairs, tags them with the radius, two-entry queue.
module rsp_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [31:0]     s_tdata,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [15:0]     cfg_data,
    output logic            q_valid,
    input  logic            q_ready,
    output rsp_pkg::rsp_job_t q_job
);
    import rsp_pkg::*;

    logic [15:0] radius_reg;
    rsp_job_t    buf_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = (cnt_reg != 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_job     = buf_reg[rptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 16'd4096;
            wptr_reg   <= 1'b0;
            rptr_reg   <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (cfg_valid) radius_reg <= cfg_data;
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= '{u_angle: s_tdata[15:0], v_angle: s_tdata[31:16],
                                   radius: radius_reg};
        end
    end
endmodule

// ===== rtl/core/rsp_cordic.sv =====
// Pipelined rotation CORDIC: cosine and sine of a binary angle in Q20.
module rsp_cordic (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [15:0]          angle,
    output rsp_pkg::trig_t       cos_q,
    output rsp_pkg::trig_t       sin_q
);
    import rsp_pkg::*;

    rsp_cordic_t st_reg [CORDIC_STEPS+1];
    rsp_cordic_t st0;
    logic signed [16:0] a;
    logic signed [CX_W-1:0] xr, yr, xo, yo;

    always_comb begin
        a = {angle[15], angle};
        st0.neg = 1'b0;
        if (a > 17'sd16384) begin
            a = a - 17'sd32768;
            st0.neg = 1'b1;
        end else if (a < -17'sd16384) begin
            a = a + 17'sd32768;
            st0.neg = 1'b1;
        end
        st0.x = CX_W'(CORDIC_GAIN);
        st0.y = '0;
        st0.z = CZ_W'(a) <<< 8;
    end

    always_ff @(posedge aclk) begin
        if (en) st_reg[0] <= st0;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i+1].neg <= st_reg[i].neg;
                if (!st_reg[i].z[CZ_W-1]) begin
                    st_reg[i+1].x <= st_reg[i].x - (st_reg[i].y >>> i);
                    st_reg[i+1].y <= st_reg[i].y + (st_reg[i].x >>> i);
                    st_reg[i+1].z <= st_reg[i].z - atan_turn24(i);
                end else begin
                    st_reg[i+1].x <= st_reg[i].x + (st_reg[i].y >>> i);
                    st_reg[i+1].y <= st_reg[i].y - (st_reg[i].x >>> i);
                    st_reg[i+1].z <= st_reg[i].z + atan_turn24(i);
                end
            end
        end
    end

    always_comb begin
        xr = (st_reg[CORDIC_STEPS].x + CX_W'(512)) >>> 10;
        yr = (st_reg[CORDIC_STEPS].y + CX_W'(512)) >>> 10;
        xo = st_reg[CORDIC_STEPS].neg ? -xr : xr;
        yo = st_reg[CORDIC_STEPS].neg ? -yr : yr;
        cos_q = xo[TRIG_W-1:0];
        sin_q = yo[TRIG_W-1:0];
    end
endmodule

// ===== rtl/core/rsp_back.sv =====
// Back end: four CORDIC lanes, product stages, radius scaling and output queue.
module rsp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  rsp_pkg::rsp_job_t q_job,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [239:0]      m_tdata
);
    import rsp_pkg::*;

    // CORDIC: 21 stages, then P1, P2, A2 mult, round/out = 25 stages
    localparam int LAT = CORDIC_STEPS + 5;
    localparam int FIFO_D = 32;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [15:0]    rad_pipe_reg [CORDIC_STEPS+1];
    trig_t cu, su, c2u, s2u, cv, sv, c2v, s2v;

    // output queue sized to cover pipeline in flight
    logic [233:0] ofifo_reg [FIFO_D];
    logic [4:0]   owp_reg, orp_reg;
    logic [5:0]   ocnt_reg, inflight;

    assign inflight = 6'($countones(vld_reg));
    assign en = 1'b1;
    assign q_ready = (ocnt_reg + inflight) < 6'(FIFO_D);

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else vld_reg <= {vld_reg[LAT-2:0], q_valid && q_ready};
    end

    rsp_cordic u_cu (.aclk, .en, .angle(q_job.u_angle), .cos_q(cu), .sin_q(su));
    rsp_cordic u_c2 (.aclk, .en, .angle({q_job.u_angle[14:0], 1'b0}),
                     .cos_q(c2u), .sin_q(s2u));
    rsp_cordic u_cv (.aclk, .en, .angle(q_job.v_angle), .cos_q(cv), .sin_q(sv));
    rsp_cordic u_c2v (.aclk, .en, .angle({q_job.v_angle[14:0], 1'b0}),
                      .cos_q(c2v), .sin_q(s2v));

    always_ff @(posedge aclk) begin
        rad_pipe_reg[0] <= q_job.radius;
        for (int i = 1; i <= CORDIC_STEPS; i++) rad_pipe_reg[i] <= rad_pipe_reg[i-1];
    end

    function automatic trig_t mq(input trig_t a, input trig_t b);
        logic signed [43:0] p;
        begin
            p = (44'(a) * 44'(b) + 44'sd524288) >>> 20;
            return p[TRIG_W-1:0];
        end
    endfunction

    // stage P1: trig row + cv^2, cv*sv, radius^2
    trig_t p1_cu, p1_su, p1_s2u, p1_c2u, p1_s2v, p1_c2v, p1_cv2, p1_cvsv;
    logic [31:0] p1_a2;
    always_ff @(posedge aclk) begin
        p1_cu <= cu; p1_su <= su; p1_s2u <= s2u; p1_c2u <= c2u;
        p1_s2v <= s2v; p1_c2v <= c2v;
        p1_cv2 <= mq(cv, cv);
        p1_cvsv <= mq(cv, sv);
        p1_a2 <= rad_pipe_reg[CORDIC_STEPS] * rad_pipe_reg[CORDIC_STEPS];
    end

    // stage P2: seven Q20 products
    trig_t p2 [7];
    logic [31:0] p2_a2;
    always_ff @(posedge aclk) begin
        p2[0] <= mq(p1_cv2, p1_s2u);
        p2[1] <= mq(p1_su, p1_s2v);
        p2[2] <= mq(p1_cu, p1_s2v);
        p2[3] <= mq(p1_cv2, p1_c2u);
        p2[4] <= mq(p1_cvsv, p1_s2u);
        p2[5] <= mq(p1_su, p1_c2v);
        p2[6] <= mq(p1_cu, p1_c2v);
        p2_a2 <= p1_a2;
    end

    // stage P3: a2 * product (Q44)
    logic signed [54:0] p3 [7];
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 7; k++) p3[k] <= $signed({1'b0, p2_a2}) * 55'(p2[k]);
    end

    function automatic logic [OUT_W-1:0] rs(input logic signed [54:0] x, input logic half);
        logic signed [54:0] r;
        begin
            r = half ? ((x + 55'sd268435456) >>> 29) : ((x + 55'sd134217728) >>> 28);
            return r[OUT_W-1:0];
        end
    endfunction

    // stage P4: rounding and packing
    logic [233:0] res_reg;
    always_ff @(posedge aclk) begin
        logic [OUT_W-1:0] r0, r1, r2, r3, r4, r5, r6;
        r0 = rs(p3[0], 1'b1);
        r1 = rs(p3[1], 1'b1);
        r2 = rs(p3[2], 1'b1);
        r3 = rs(p3[3], 1'b0);
        r4 = rs(p3[4], 1'b0);
        r5 = rs(p3[5], 1'b0);
        r6 = rs(p3[6], 1'b0);
        res_reg <= {r6, r5, -r4, -r1, r2, r3, r2, r1, r0};
    end

    logic push, pop;
    assign push = vld_reg[LAT-1];
    assign m_tvalid = (ocnt_reg != '0);
    assign pop = m_tvalid && m_tready;
    assign m_tdata = {6'd0, ofifo_reg[orp_reg]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owp_reg <= '0; orp_reg <= '0; ocnt_reg <= '0;
        end else begin
            if (push) owp_reg <= owp_reg + 5'd1;
            if (pop) orp_reg <= orp_reg + 5'd1;
            ocnt_reg <= ocnt_reg + {5'd0, push} - {5'd0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) ofifo_reg[owp_reg] <= res_reg;
    end
endmodule

// ===== rtl/core/roman_surface_point_eval.sv =====
// Top level of the Roman surface point evaluator.
//  channel | dir | payload
//  s_      | in  | tdata[15:0] u_angle, [31:16] v_angle
//  m_      | out | tdata 9 x 26-bit signed Q16 fields
//  cfg_    | in  | radius, unsigned Q4.12
// One item per cycle sustained while the result queue has room. Items pass the
// input queue, 20 CORDIC stages and four product/scale stages. A 32-entry result
// queue absorbs m_tready stalls; input stalls once results in flight fill it.
// Reset is synchronous active low and sets radius to 1.0.
module roman_surface_point_eval (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // u_angle, v_angle
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata,   // point_x,y,z, du_x,y,z, dv_x,y,z, zero pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);
    import rsp_pkg::*;

    logic     q_valid, q_ready;
    rsp_job_t q_job;

    rsp_front u_front (.aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
                       .cfg_valid, .cfg_ready, .cfg_data,
                       .q_valid, .q_ready, .q_job);
    rsp_back u_back (.aclk, .aresetn, .q_valid, .q_ready, .q_job,
                     .m_tvalid, .m_tready, .m_tdata);
endmodule

// ===== rtl/core/rsp_checker.sv =====
// Port-level checker for the Roman surface evaluator, bound to the top level.
module rsp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [239:0] m_tdata,
    input logic         cfg_ready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[239:234] == 6'd0)
        else $error("pad bits set");
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("cfg not ready");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind roman_surface_point_eval rsp_checker u_rsp_checker (.*);

// ===== sim/roman_surface_point_eval_checker.sv =====
// Watches the evaluator's streams, predicts each surface point and compares.
`timescale 1ns / 100ps

module roman_surface_point_eval_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [239:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    output int           fail_count,
    output int           pending_count,
    output int           point_count
);
    import rsp_pkg::*;

    localparam int NUM_FIELDS = 9;
    localparam int ATAN_TBL [CORDIC_STEPS] = '{2097152, 1238021, 654136, 332050,
        166669, 83416, 41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5};

    logic [15:0]  radius_q;
    logic [239:0] expected_points [$];

    function automatic longint floor_shift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint round_shift(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // cosine and sine, Q20
    function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                    output longint s);
        longint a, x, y, z, dx, dy;
        bit flip;
        a = longint'($signed(ang));
        flip = 0;
        if (a > 16384) begin
            a -= 32768;
            flip = 1;
        end else if (a < -16384) begin
            a += 32768;
            flip = 1;
        end
        x = CORDIC_GAIN;
        y = 0;
        z = a * 256;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        c = round_shift(x, 10);
        s = round_shift(y, 10);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic longint mul20(longint a, longint b);
        return round_shift(a * b, 20);
    endfunction

    function automatic logic [239:0] surface_point(logic [15:0] u, logic [15:0] v,
                                                   logic [15:0] rad);
        longint cu, su, c2u, s2u, cv, sv, c2v, s2v, a2, cv2, cvsv;
        longint f [NUM_FIELDS];
        logic [239:0] packed_point;
        sin_cos(u, cu, su);
        sin_cos(u << 1, c2u, s2u);
        sin_cos(v, cv, sv);
        sin_cos(v << 1, c2v, s2v);
        a2 = longint'(rad) * longint'(rad);
        cv2 = mul20(cv, cv);
        cvsv = mul20(cv, sv);
        f[0] = round_shift(a2 * mul20(cv2, s2u), 29);
        f[1] = round_shift(a2 * mul20(su, s2v), 29);
        f[2] = round_shift(a2 * mul20(cu, s2v), 29);
        f[3] = round_shift(a2 * mul20(cv2, c2u), 28);
        f[4] = f[2];
        f[5] = -f[1];
        f[6] = -round_shift(a2 * mul20(cvsv, s2u), 28);
        f[7] = round_shift(a2 * mul20(su, c2v), 28);
        f[8] = round_shift(a2 * mul20(cu, c2v), 28);
        packed_point = '0;
        for (int k = 0; k < NUM_FIELDS; k++)
            packed_point[k*OUT_W +: OUT_W] = f[k][OUT_W-1:0];
        return packed_point;
    endfunction

    assign pending_count = expected_points.size();

    always @(posedge aclk) begin
        logic [239:0] want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            radius_q <= 16'd4096;
            fail_count <= 0;
            point_count <= 0;
            expected_points.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                radius_q <= cfg_data;
            if (s_tvalid && s_tready)
                expected_points.push_back(surface_point(s_tdata[15:0],
                                                        s_tdata[31:16], radius_q));
            if (m_tvalid && m_tready) begin
                point_count <= point_count + 1;
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    errs++;
                end else begin
                    want = expected_points.pop_front();
                    for (int k = 0; k < NUM_FIELDS; k++)
                        if (want[k*OUT_W +: OUT_W] !== m_tdata[k*OUT_W +: OUT_W]) begin
                            $display("%0t: field %0d expected %h got %h", $time, k,
                                     want[k*OUT_W +: OUT_W], m_tdata[k*OUT_W +: OUT_W]);
                            errs++;
                        end
                    if (want[239:NUM_FIELDS*OUT_W] !== m_tdata[239:NUM_FIELDS*OUT_W]) begin
                        $display("%0t: pad expected 0 got %h", $time,
                                 m_tdata[239:NUM_FIELDS*OUT_W]);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

// ===== sim/roman_surface_point_eval_test.sv =====
// Testbench top: drives angle pairs and radius settings, reports the verdict.
`timescale 1ns / 100ps

module roman_surface_point_eval_test;
    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [239:0] m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;
    int           fail_count, pending_count, point_count;
    int           angle_count = 0;

    localparam logic [15:0] RADII [5] = '{16'd0, 16'hFFFF, 16'd4096, 16'd1, 16'd23170};

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    roman_surface_point_eval dut (.*);

    roman_surface_point_eval_checker checker_i (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called at a falling edge; ready only moves at rising edges
    task automatic send_angles(logic [15:0] u, logic [15:0] v, bit bursty);
        int g;
        g = bursty ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {v, u};
        while (!s_tready) @(negedge aclk);
        angle_count++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic set_radius(logic [15:0] r);
        cfg_valid <= 1;
        cfg_data <= r;
        while (!cfg_ready) @(negedge aclk);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // result side stalls
    initial begin
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(10, 60)) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    initial begin
        logic [15:0] special [12];
        special = '{16'h0000, 16'hFFFF, 16'h4000, 16'h4001, 16'h8000, 16'h7FFF,
                    16'hC000, 16'hBFFF, 16'h2000, 16'hC001, 16'h5555, 16'hAAAA};
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed: quadrant edges at reset radius
        for (int i = 0; i < 12; i++)
            send_angles(special[i], special[11 - i], 0);
        for (int r = 0; r < 5; r++) begin
            drain();
            set_radius(RADII[r]);
            if (r == 1)
                for (int i = 0; i < 12; i++)
                    send_angles(special[i], special[(i + 5) % 12], 0);
            for (int n = 0; n < 300; n++) begin
                send_angles(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            (n % 100) < 30);
                if (n == 150) drain();
            end
        end
        drain();
        set_radius(16'($urandom_range(0, 65535)));
        for (int n = 0; n < 50; n++)
            send_angles(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 0);
        drain();
        $display("Covered %0d angle pairs, %0d results, radii 0, 1, 1.0, max and random.",
                 angle_count, point_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/rsp_pkg.sv
rtl/core/rsp_front.sv
rtl/core/rsp_cordic.sv
rtl/core/rsp_back.sv
rtl/core/roman_surface_point_eval.sv
rtl/core/rsp_checker.sv
sim/roman_surface_point_eval_checker.sv
sim/roman_surface_point_eval_test.sv
